### src/stlx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stlx_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int LINE_WIDTH_DEF   = 24;

    // result field widths
    localparam int KIND_W  = 5;
    localparam int START_W = 32;
    localparam int LEN_W   = 32;
    localparam int LINE_W  = 24;

    // at most four tokens come out of one input word
    localparam int MAX_RES = 4;
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int RES_CW  = $clog2(MAX_RES + 1);

    // bundles held between scanner and serialiser
    localparam int Q_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        K_LPAREN   = 5'd0,
        K_RPAREN   = 5'd1,
        K_LBRACE   = 5'd2,
        K_RBRACE   = 5'd3,
        K_LBRACKET = 5'd4,
        K_RBRACKET = 5'd5,
        K_COMMA    = 5'd6,
        K_DOT      = 5'd7,
        K_MINUS    = 5'd8,
        K_PLUS     = 5'd9,
        K_SEMI     = 5'd10,
        K_SLASH    = 5'd11,
        K_STAR     = 5'd12,
        K_BANG     = 5'd13,
        K_BANG_EQ  = 5'd14,
        K_EQ       = 5'd15,
        K_EQ_EQ    = 5'd16,
        K_LT       = 5'd17,
        K_LT_EQ    = 5'd18,
        K_SHL      = 5'd19,
        K_GT       = 5'd20,
        K_GT_EQ    = 5'd21,
        K_SHR      = 5'd22,
        K_ASSIGN   = 5'd23,
        K_STRING   = 5'd24,
        K_NUMBER   = 5'd25,
        K_IDENT    = 5'd26,
        K_EOF      = 5'd27
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [LINE_W-1:0]  line;
    } t_token;

    typedef struct packed {
        logic [RES_CW-1:0]         count;
        t_token [MAX_RES-1:0]      tok;
    } t_bundle;

    typedef struct packed {
        logic    avail;
        t_bundle bundle;
    } t_q_head;

endpackage

`default_nettype wire

### src/stlx_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stlx_front #(
    parameter int OFFSET_WIDTH = stlx_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = stlx_pkg::LINE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_char_byte,
    input  logic              i_char_valid,
    input  logic              i_end_of_source,
    input  logic              i_accept,
    output logic              o_push,
    output stlx_pkg::t_bundle o_bundle
);
    import stlx_pkg::*;

    typedef enum logic [11:0] {
        M_IDLE    = 12'b0000_0000_0001,
        M_BANG    = 12'b0000_0000_0010,
        M_EQ      = 12'b0000_0000_0100,
        M_LT      = 12'b0000_0000_1000,
        M_GT      = 12'b0000_0001_0000,
        M_COLON   = 12'b0000_0010_0000,
        M_COMMENT = 12'b0000_0100_0000,
        M_STRING  = 12'b0000_1000_0000,
        M_INT     = 12'b0001_0000_0000,
        M_DOT     = 12'b0010_0000_0000,
        M_FRAC    = 12'b0100_0000_0000,
        M_IDENT   = 12'b1000_0000_0000
    } t_mode;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_hit;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX  = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
    localparam logic [OFFSET_WIDTH:0]   LEN_ONE  = (OFFSET_WIDTH + 1)'(1);
    localparam logic [OFFSET_WIDTH:0]   LEN_ZERO = '0;
    localparam logic [RES_CW-1:0]       CNT_ONE  = RES_CW'(1);

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic t_hit punct(logic [7:0] c);
        t_hit h;
        h.hit  = 1'b1;
        h.kind = K_EOF;
        unique case (c)
            CH_LPAR:  h.kind = K_LPAREN;
            CH_RPAR:  h.kind = K_RPAREN;
            CH_LBRC:  h.kind = K_LBRACE;
            CH_RBRC:  h.kind = K_RBRACE;
            CH_LBRK:  h.kind = K_LBRACKET;
            CH_RBRK:  h.kind = K_RBRACKET;
            CH_COMMA: h.kind = K_COMMA;
            CH_DOT:   h.kind = K_DOT;
            CH_MINUS: h.kind = K_MINUS;
            CH_PLUS:  h.kind = K_PLUS;
            CH_SEMI:  h.kind = K_SEMI;
            CH_SLASH: h.kind = K_SLASH;
            CH_STAR:  h.kind = K_STAR;
            default:  h.hit  = 1'b0;
        endcase
        return h;
    endfunction

    // second byte of a held operator
    function automatic t_hit op_pair(t_mode m, logic [7:0] c);
        t_hit h;
        h.hit  = 1'b0;
        h.kind = K_EOF;
        priority if (c == CH_EQ) begin
            h.hit = 1'b1;
            unique case (m)
                M_BANG:  h.kind = K_BANG_EQ;
                M_EQ:    h.kind = K_EQ_EQ;
                M_LT:    h.kind = K_LT_EQ;
                M_GT:    h.kind = K_GT_EQ;
                default: h.kind = K_ASSIGN;
            endcase
        end else if ((m == M_LT) && (c == CH_LT)) begin
            h.hit  = 1'b1;
            h.kind = K_SHL;
        end else if ((m == M_GT) && (c == CH_GT)) begin
            h.hit  = 1'b1;
            h.kind = K_SHR;
        end else begin
            h.hit  = 1'b0;
        end
        return h;
    endfunction

    // held operator byte standing alone; a lone colon gives nothing
    function automatic t_hit op_single(t_mode m);
        t_hit h;
        h.hit  = 1'b1;
        h.kind = K_EOF;
        unique case (m)
            M_BANG:  h.kind = K_BANG;
            M_EQ:    h.kind = K_EQ;
            M_LT:    h.kind = K_LT;
            M_GT:    h.kind = K_GT;
            default: h.hit  = 1'b0;
        endcase
        return h;
    endfunction

    function automatic logic [OFFSET_WIDTH:0] span(logic [OFFSET_WIDTH-1:0] a_end,
                                                   logic [OFFSET_WIDTH-1:0] a_start);
        return {1'b0, a_end} - {1'b0, a_start};
    endfunction

    function automatic logic [LINE_WIDTH-1:0] line_inc(logic [LINE_WIDTH-1:0] l);
        return (l != LINE_MAX) ? l + LINE_ONE : l;
    endfunction

    function automatic t_token mk_tok(t_kind k, logic [OFFSET_WIDTH-1:0] start,
                                      logic [OFFSET_WIDTH:0] len,
                                      logic [LINE_WIDTH-1:0] l);
        logic [63:0] s;
        logic [64:0] n;
        logic [31:0] w;
        t_token      t;
        s        = 64'(start);
        n        = 65'(len);
        w        = 32'(l);
        t.kind   = k;
        t.start  = s[START_W-1:0];
        t.length = n[LEN_W-1:0];
        t.line   = w[LINE_W-1:0];
        return t;
    endfunction

    t_mode                   r_mode, n_mode;
    logic [OFFSET_WIDTH-1:0] r_lexstart, n_lexstart;
    logic [OFFSET_WIDTH-1:0] r_offset, n_offset;
    logic [OFFSET_WIDTH-1:0] r_dot, n_dot;
    logic [LINE_WIDTH-1:0]   r_line, n_line;

    logic [7:0]              c;
    logic [OFFSET_WIDTH-1:0] pos;
    logic                    rescan;
    logic [RES_CW-1:0]       cnt;
    t_token [MAX_RES-1:0]    toks;
    t_hit                    pair, single, pk, fl_single;

    assign c    = i_char_byte;
    assign pos  = r_offset;
    assign pair = op_pair(r_mode, i_char_byte);
    assign single = op_single(r_mode);
    assign pk   = punct(i_char_byte);

    always_comb begin
        n_mode     = r_mode;
        n_lexstart = r_lexstart;
        n_offset   = r_offset;
        n_dot      = r_dot;
        n_line     = r_line;
        cnt        = '0;
        toks       = '0;
        rescan     = 1'b0;
        fl_single  = '0;

        if (i_char_valid) begin
            unique case (r_mode)
                M_BANG, M_EQ, M_LT, M_GT, M_COLON: begin
                    if (pair.hit) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(pair.kind, r_lexstart,
                                                       span(pos, r_lexstart) + LEN_ONE, n_line);
                        cnt = cnt + CNT_ONE;
                        n_mode = M_IDLE;
                    end else begin
                        if (single.hit) begin
                            toks[cnt[RES_IW-1:0]] = mk_tok(single.kind, r_lexstart, LEN_ONE,
                                                           n_line);
                            cnt = cnt + CNT_ONE;
                        end
                        rescan = 1'b1;
                    end
                end
                M_COMMENT: begin
                    rescan = (c == CH_NL);
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(K_STRING, r_lexstart,
                                                       span(pos, r_lexstart) + LEN_ONE, n_line);
                        cnt = cnt + CNT_ONE;
                        n_mode = M_IDLE;
                    end else if (c == CH_NL) begin
                        n_line = line_inc(n_line);
                    end
                end
                M_INT: begin
                    if (!is_digit(c)) begin
                        if (c == CH_DOT) begin
                            n_dot  = pos;
                            n_mode = M_DOT;
                        end else begin
                            toks[cnt[RES_IW-1:0]] = mk_tok(K_NUMBER, r_lexstart,
                                                           span(pos, r_lexstart), n_line);
                            cnt = cnt + CNT_ONE;
                            rescan = 1'b1;
                        end
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        n_mode = M_FRAC;
                    end else begin
                        // digits then a dot not followed by a digit: number, then the dot
                        toks[cnt[RES_IW-1:0]] = mk_tok(K_NUMBER, r_lexstart,
                                                       span(r_dot, r_lexstart), n_line);
                        cnt = cnt + CNT_ONE;
                        toks[cnt[RES_IW-1:0]] = mk_tok(K_DOT, r_dot, LEN_ONE, n_line);
                        cnt = cnt + CNT_ONE;
                        rescan = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (!is_digit(c)) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(K_NUMBER, r_lexstart,
                                                       span(pos, r_lexstart), n_line);
                        cnt = cnt + CNT_ONE;
                        rescan = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (!(is_digit(c) || is_alpha(c))) begin
                        toks[cnt[RES_IW-1:0]] = mk_tok(K_IDENT, r_lexstart,
                                                       span(pos, r_lexstart), n_line);
                        cnt = cnt + CNT_ONE;
                        rescan = 1'b1;
                    end
                end
                default: begin
                    rescan = 1'b1;
                end
            endcase

            if (rescan) begin
                n_mode = M_IDLE;
                if (pk.hit) begin
                    toks[cnt[RES_IW-1:0]] = mk_tok(pk.kind, pos, LEN_ONE, n_line);
                    cnt = cnt + CNT_ONE;
                end else begin
                    n_lexstart = pos;
                    unique case (c)
                        CH_NL:    n_line = line_inc(n_line);
                        CH_BANG:  n_mode = M_BANG;
                        CH_EQ:    n_mode = M_EQ;
                        CH_LT:    n_mode = M_LT;
                        CH_GT:    n_mode = M_GT;
                        CH_COLON: n_mode = M_COLON;
                        CH_HASH:  n_mode = M_COMMENT;
                        CH_QUOTE: n_mode = M_STRING;
                        default: begin
                            if (is_digit(c)) begin
                                n_mode = M_INT;
                            end else if (is_alpha(c)) begin
                                n_mode = M_IDENT;
                            end
                        end
                    endcase
                end
            end

            if (pos != OFF_MAX) begin
                n_offset = pos + OFFSET_WIDTH'(1);
            end
        end

        if (i_end_of_source) begin
            fl_single = op_single(n_mode);
            unique case (n_mode)
                M_BANG, M_EQ, M_LT, M_GT: begin
                    toks[cnt[RES_IW-1:0]] = mk_tok(fl_single.kind, n_lexstart, LEN_ONE, n_line);
                    cnt = cnt + CNT_ONE;
                end
                M_INT, M_FRAC: begin
                    toks[cnt[RES_IW-1:0]] = mk_tok(K_NUMBER, n_lexstart,
                                                   span(n_offset, n_lexstart), n_line);
                    cnt = cnt + CNT_ONE;
                end
                M_DOT: begin
                    toks[cnt[RES_IW-1:0]] = mk_tok(K_NUMBER, n_lexstart,
                                                   span(n_dot, n_lexstart), n_line);
                    cnt = cnt + CNT_ONE;
                    toks[cnt[RES_IW-1:0]] = mk_tok(K_DOT, n_dot, LEN_ONE, n_line);
                    cnt = cnt + CNT_ONE;
                end
                M_IDENT: begin
                    toks[cnt[RES_IW-1:0]] = mk_tok(K_IDENT, n_lexstart,
                                                   span(n_offset, n_lexstart), n_line);
                    cnt = cnt + CNT_ONE;
                end
                default: begin
                end
            endcase
            toks[cnt[RES_IW-1:0]] = mk_tok(K_EOF, n_offset, LEN_ZERO, n_line);
            cnt = cnt + CNT_ONE;
            // a fresh source starts after the end marker
            n_mode     = M_IDLE;
            n_lexstart = '0;
            n_offset   = '0;
            n_dot      = '0;
            n_line     = LINE_ONE;
        end
    end

    assign o_push         = i_accept && (cnt != '0);
    assign o_bundle.count = cnt;
    assign o_bundle.tok   = toks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_lexstart <= '0;
            r_offset   <= '0;
            r_dot      <= '0;
            r_line     <= LINE_ONE;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_lexstart <= n_lexstart;
            r_offset   <= n_offset;
            r_dot      <= n_dot;
            r_line     <= n_line;
        end
    end

endmodule

`default_nettype wire

### src/stlx_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module stlx_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stlx_pkg::t_bundle i_bundle,
    input  logic              i_pop,
    output logic              o_full,
    output stlx_pkg::t_q_head o_head
);
    import stlx_pkg::*;

    localparam int QAW = $clog2(Q_DEPTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);
    localparam logic [QAW-1:0] PTR_LAST = QAW'(Q_DEPTH - 1);

    t_bundle        r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    assign o_full        = (r_cnt == QCW'(Q_DEPTH));
    assign o_head.avail  = (r_cnt != '0);
    assign o_head.bundle = r_mem[r_rd];

endmodule

`default_nettype wire

### src/stlx_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stlx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stlx_pkg::t_q_head i_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output stlx_pkg::t_token  o_token,
    output logic              o_last
);
    import stlx_pkg::*;

    logic                r_out_vld;
    t_token              r_tok;
    logic                r_last;
    logic [RES_IW-1:0]   r_idx;
    logic                load;
    logic                head_last;

    // next token goes out when the queue has a head and the output register is free or being taken
    assign load      = i_head.avail && (!r_out_vld || i_pop);
    assign head_last = (RES_CW'(r_idx) + RES_CW'(1)) == i_head.bundle.count;
    assign o_q_pop   = load && head_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
                r_idx     <= head_last ? '0 : r_idx + RES_IW'(1);
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= i_head.bundle.tok[r_idx];
            r_last <= head_last;
        end
    end

    assign o_empty = !r_out_vld;
    assign o_token = r_tok;
    assign o_last  = r_last;

endmodule

`default_nettype wire

### src/source_text_lexer_unit.sv
// channel   direction  handshake              payload
// source    in         push / full            i_char_byte, i_char_valid, i_end_of_source
// tokens    out        empty / pop            o_token_kind, o_token_start, o_token_length,
//                                             o_token_line, o_last_of_run
//
// one source word is taken per cycle while the bundle queue has room; the scanner
// turns it into up to four tokens in that same cycle
// the serialiser hands out one token per cycle while pop is high, so a word giving n tokens
// stays at the queue head until all n are taken; a token passes from the bundle queue into the output register
// synchronous reset: i_rst_n low at a clock edge empties everything, line back to 1
// pop held low keeps the token on the ports; further bundles then fill the queue and full goes high
`timescale 1ns / 1ps
`default_nettype none

module source_text_lexer_unit #(
    parameter int OFFSET_WIDTH = stlx_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = stlx_pkg::LINE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   i_char_byte,
    input  logic                         i_char_valid,
    input  logic                         i_end_of_source,
    output logic                         empty,
    input  logic                         pop,
    output logic [stlx_pkg::KIND_W-1:0]  o_token_kind,
    output logic [stlx_pkg::START_W-1:0] o_token_start,
    output logic [stlx_pkg::LEN_W-1:0]   o_token_length,
    output logic [stlx_pkg::LINE_W-1:0]  o_token_line,
    output logic                         o_last_of_run
);
    import stlx_pkg::*;

    logic    accept;
    logic    q_push, q_pop, q_full;
    t_bundle bundle;
    t_q_head head;
    t_token  tok;

    assign accept = push && !q_full;
    assign full   = q_full;

    stlx_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_char_byte     (i_char_byte),
        .i_char_valid    (i_char_valid),
        .i_end_of_source (i_end_of_source),
        .i_accept        (accept),
        .o_push          (q_push),
        .o_bundle        (bundle)
    );

    stlx_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (bundle),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_head   (head)
    );

    stlx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_q_pop (q_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_token (tok),
        .o_last  (o_last_of_run)
    );

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;
    assign o_token_line   = tok.line;

endmodule

`default_nettype wire

### src/stlx_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module stlx_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic [stlx_pkg::KIND_W-1:0]  o_token_kind,
    input logic [stlx_pkg::START_W-1:0] o_token_start,
    input logic [stlx_pkg::LEN_W-1:0]   o_token_length,
    input logic [stlx_pkg::LINE_W-1:0]  o_token_line,
    input logic                         o_last_of_run
);
    import stlx_pkg::*;

    // a token not taken stays on the ports unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_token_kind) && $stable(o_token_start)
                              && $stable(o_token_length) && $stable(o_token_line)
                              && $stable(o_last_of_run)))
        else $error("token changed while held");

    a_eof_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_token_kind == K_EOF)) |-> (o_token_length == '0))
        else $error("end token with nonzero length");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_token_kind == K_EOF)) |-> o_last_of_run)
        else $error("end token not last of its run");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

endmodule

bind source_text_lexer_unit stlx_checker u_stlx_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_token_kind   (o_token_kind),
    .o_token_start  (o_token_start),
    .o_token_length (o_token_length),
    .o_token_line   (o_token_line),
    .o_last_of_run  (o_last_of_run)
);

`default_nettype wire
